@@ rtl/arc_pkg.sv @@
// ----------------------------------------------------------------------------
// arc_pkg
// shared types and constants of the address range cache
// ----------------------------------------------------------------------------
package arc_pkg;

    localparam int SLOTS_DEF  = 16;
    localparam int LIMIT_W    = 5;
    localparam int IN_W       = 248;
    localparam int OUT_W      = 296;
    localparam int QDEPTH     = 2;

    typedef enum logic [2:0] {
        OP_LOOKUP    = 3'd0,
        OP_ADD       = 3'd1,
        OP_REMOVE    = 3'd2,
        OP_TRANSLATE = 3'd3,
        OP_FLUSH     = 3'd4
    } t_op;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EXIST = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;

    typedef struct packed {
        logic        has_mapping;
        logic [15:0] map_id;
        logic [31:0] access_flags;
        logic [63:0] offset_in_file;
        logic [63:0] range_end;
        logic [63:0] addr;
        logic [2:0]  op;
        logic        known;
    } t_cmd;

    typedef struct packed {
        logic        evicted;
        logic [63:0] translated;
        logic [31:0] hit_flags;
        logic [63:0] hit_offset;
        logic [63:0] hit_end;
        logic [63:0] hit_start;
        logic [1:0]  status;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVICT,
        S_AGE,
        S_RESULT
    } t_state;

endpackage

@@ rtl/arc_front.sv @@
// ----------------------------------------------------------------------------
// arc_front
// accepts items, classifies the op and queues commands for the back end
// ----------------------------------------------------------------------------
module arc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_op,
    input  logic [63:0]           i_addr,
    input  logic [63:0]           i_range_end,
    input  logic [63:0]           i_offset_in_file,
    input  logic [31:0]           i_access_flags,
    input  logic [15:0]           i_map_id,
    input  logic                  i_has_mapping,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_ready,
    output arc_pkg::t_cmd         o_cmd
);

    arc_pkg::t_cmd r_q [arc_pkg::QDEPTH];
    logic [0:0]    r_wp, r_rp;
    logic [1:0]    r_cnt;
    arc_pkg::t_cmd w_in;
    logic          w_push, w_pop;

    always_comb begin
        w_in.has_mapping    = i_has_mapping;
        w_in.map_id         = i_map_id;
        w_in.access_flags   = i_access_flags;
        w_in.offset_in_file = i_offset_in_file;
        w_in.range_end      = i_range_end;
        w_in.addr           = i_addr;
        w_in.op             = i_op;
        w_in.known          = (i_op <= arc_pkg::OP_FLUSH);
    end

    assign o_ready     = (r_cnt != 2'(arc_pkg::QDEPTH));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(arc_pkg::QDEPTH)) else $error("queue overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !o_cmd_valid) else $error("pop when empty");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("count step");
`endif

endmodule

@@ rtl/arc_back.sv @@
// ----------------------------------------------------------------------------
// arc_back
// sequencer that scans the slots, updates recency and forms the result
// ----------------------------------------------------------------------------
module arc_back #(
    parameter int SLOTS = arc_pkg::SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    output logic                         o_cmd_ready,
    input  arc_pkg::t_cmd                i_cmd,
    input  logic [arc_pkg::LIMIT_W-1:0]  i_limit,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output arc_pkg::t_res                o_res
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [63:0] r_start [SLOTS];
    logic [63:0] r_end   [SLOTS];
    logic [63:0] r_off   [SLOTS];
    logic [31:0] r_flags [SLOTS];
    logic [15:0] r_map   [SLOTS];
    logic        r_named [SLOTS];
    logic [IW-1:0] r_age [SLOTS];
    logic [SLOTS-1:0] r_valid;
    logic [CW-1:0] r_live;

    arc_pkg::t_state r_st, n_st;
    arc_pkg::t_cmd   r_cmd;
    arc_pkg::t_res   r_res, n_res;
    logic            r_oval;
    logic [CW-1:0]   r_idx;
    logic            r_found;
    logic [IW-1:0]   r_hit;
    logic            r_ev_found;
    logic [IW-1:0]   r_ev;
    logic            r_free_found;
    logic [IW-1:0]   r_free;
    logic            r_evicted;

    logic [IW-1:0]   w_i;
    logic            w_match;
    logic [CW-1:0]   w_lim;
    logic            w_full;

    assign w_i     = r_idx[IW-1:0];
    assign w_match = r_valid[w_i] && (r_start[w_i] <= r_cmd.addr)
                     && (r_cmd.addr < r_end[w_i]);

    always_comb begin
        if (i_limit == '0) begin
            w_lim = CW'(1);
        end else if (32'(i_limit) > 32'(SLOTS)) begin
            w_lim = CW'(SLOTS);
        end else begin
            w_lim = CW'(i_limit);
        end
    end
    assign w_full = (r_live >= w_lim) && (r_live != '0);

    assign o_cmd_ready = (r_st == arc_pkg::S_IDLE) && !r_oval;
    assign o_res_valid = r_oval;
    assign o_res       = r_res;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            arc_pkg::S_IDLE: begin
                if (i_cmd_valid && o_cmd_ready) begin
                    n_st = arc_pkg::S_SCAN;
                end
            end
            arc_pkg::S_SCAN: begin
                if (r_idx == CW'(SLOTS - 1)) begin
                    n_st = arc_pkg::S_EVICT;
                end
            end
            arc_pkg::S_EVICT:  n_st = arc_pkg::S_AGE;
            arc_pkg::S_AGE:    n_st = arc_pkg::S_RESULT;
            arc_pkg::S_RESULT: n_st = arc_pkg::S_IDLE;
            default:           n_st = arc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= arc_pkg::S_IDLE;
            r_oval  <= 1'b0;
            r_valid <= '0;
            r_live  <= '0;
            for (int k = 0; k < SLOTS; k++) begin
                r_age[k] <= '0;
            end
        end else begin
            r_st <= n_st;
            if (r_oval && i_res_ready) begin
                r_oval <= 1'b0;
            end
            unique case (r_st)
                arc_pkg::S_IDLE: begin
                    if (i_cmd_valid && o_cmd_ready) begin
                        r_cmd        <= i_cmd;
                        r_idx        <= '0;
                        r_found      <= 1'b0;
                        r_ev_found   <= 1'b0;
                        r_free_found <= 1'b0;
                        r_evicted    <= 1'b0;
                        r_hit        <= '0;
                        r_ev         <= '0;
                        r_free       <= '0;
                    end
                end
                arc_pkg::S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (w_match && !r_found) begin
                        r_found <= 1'b1;
                        r_hit   <= w_i;
                    end
                    if (r_valid[w_i] && !r_ev_found
                        && (CW'(r_age[w_i]) == r_live - 1'b1)) begin
                        r_ev_found <= 1'b1;
                        r_ev       <= w_i;
                    end
                    if (!r_valid[w_i] && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free       <= w_i;
                    end
                end
                arc_pkg::S_EVICT: begin
                    if (r_cmd.op == arc_pkg::OP_ADD && !r_found && w_full && r_ev_found) begin
                        r_valid[r_ev] <= 1'b0;
                        r_live        <= r_live - 1'b1;
                        r_evicted     <= 1'b1;
                        if (!r_free_found || (r_ev < r_free)) begin
                            r_free <= r_ev;
                        end
                        r_free_found  <= 1'b1;
                        for (int k = 0; k < SLOTS; k++) begin
                            if (r_valid[k] && r_age[k] > r_age[r_ev]) begin
                                r_age[k] <= r_age[k] - 1'b1;
                            end
                        end
                    end
                end
                arc_pkg::S_AGE: begin
                    if (r_cmd.known) begin
                        case (r_cmd.op)
                            arc_pkg::OP_LOOKUP, arc_pkg::OP_TRANSLATE: begin
                                if (r_found) begin
                                    for (int k = 0; k < SLOTS; k++) begin
                                        if (r_valid[k] && r_age[k] < r_age[r_hit]) begin
                                            r_age[k] <= r_age[k] + 1'b1;
                                        end
                                    end
                                    r_age[r_hit] <= '0;
                                end
                            end
                            arc_pkg::OP_ADD: begin
                                if (!r_found && r_free_found) begin
                                    for (int k = 0; k < SLOTS; k++) begin
                                        if (r_valid[k]) begin
                                            r_age[k] <= r_age[k] + 1'b1;
                                        end
                                    end
                                    r_valid[r_free] <= 1'b1;
                                    r_age[r_free]   <= '0;
                                    r_live          <= r_live + 1'b1;
                                end
                            end
                            arc_pkg::OP_REMOVE: begin
                                if (r_found) begin
                                    r_valid[r_hit] <= 1'b0;
                                    r_live         <= r_live - 1'b1;
                                    for (int k = 0; k < SLOTS; k++) begin
                                        if (r_valid[k] && r_age[k] > r_age[r_hit]) begin
                                            r_age[k] <= r_age[k] - 1'b1;
                                        end
                                    end
                                end
                            end
                            arc_pkg::OP_FLUSH: begin
                                r_valid <= '0;
                                r_live  <= '0;
                                for (int k = 0; k < SLOTS; k++) begin
                                    r_age[k] <= '0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                arc_pkg::S_RESULT: begin
                    r_oval <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_res = r_res;
        if (r_st == arc_pkg::S_EVICT) begin
            n_res = '0;
            if (!r_cmd.known) begin
                n_res.status = arc_pkg::ST_MISS;
            end else if (r_cmd.op != arc_pkg::OP_FLUSH) begin
                if (r_found) begin
                    n_res.hit_start  = r_start[r_hit];
                    n_res.hit_end    = r_end[r_hit];
                    n_res.hit_offset = r_off[r_hit];
                    n_res.hit_flags  = r_flags[r_hit];
                    n_res.status     = (r_cmd.op == arc_pkg::OP_ADD)
                                       ? arc_pkg::ST_EXIST : arc_pkg::ST_OK;
                    if (r_cmd.op == arc_pkg::OP_TRANSLATE && r_named[r_hit]
                        && r_map[r_hit] == r_cmd.map_id) begin
                        n_res.translated = r_cmd.addr - r_start[r_hit];
                    end
                end else if (r_cmd.op != arc_pkg::OP_ADD) begin
                    n_res.status = arc_pkg::ST_MISS;
                end
            end
        end
        if (r_st == arc_pkg::S_AGE) begin
            if (r_res.translated != '0 || (r_cmd.op == arc_pkg::OP_TRANSLATE
                && r_found && r_named[r_hit] && r_map[r_hit] == r_cmd.map_id)) begin
                n_res.translated = r_res.translated + r_off[r_hit];
            end
            n_res.evicted = r_evicted;
        end
    end

    // slot payload and result, no reset
    always_ff @(posedge i_clk) begin
        if (r_st == arc_pkg::S_AGE && r_cmd.known && r_cmd.op == arc_pkg::OP_ADD
            && !r_found && r_free_found) begin
            r_start[r_free] <= r_cmd.addr;
            r_end[r_free]   <= r_cmd.range_end;
            r_off[r_free]   <= r_cmd.offset_in_file;
            r_flags[r_free] <= r_cmd.access_flags;
            r_map[r_free]   <= r_cmd.map_id;
            r_named[r_free] <= r_cmd.has_mapping;
        end
        r_res <= n_res;
    end

`ifndef SYNTHESIS
    a_live_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CW'(SLOTS)) else $error("live count above slots");
    a_live_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == arc_pkg::S_IDLE) |-> (32'(r_live) == $countones(r_valid)))
        else $error("live count mismatch");
    a_res_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == arc_pkg::S_RESULT) |-> !r_oval) else $error("result overrun");
`endif

endmodule

@@ rtl/address_range_cache_lru_core.sv @@
// sequence: the back end scans the slots, one slot compared per cycle,
// then passes its evict, age and result states before the result is valid
// items wait in a two-entry queue until the back end is idle with its result taken
// reset: synchronous active low; cache empty, entry limit 16
// ----------------------------------------------------------------------------
// address_range_cache_lru_core
// fully associative address range cache with least recently used replacement
// ----------------------------------------------------------------------------
module address_range_cache_lru_core #(
    parameter int SLOTS = arc_pkg::SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // op, addr, range_end, offset_in_file, access_flags, map_id, has_mapping, pad
    input  logic [arc_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // status, hit_start, hit_end, hit_offset, hit_flags, translated, evicted, pad
    output logic [arc_pkg::OUT_W-1:0] m_axis_tdata,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [4:0]                i_cfg_data
);

    logic [arc_pkg::LIMIT_W-1:0] r_limit;
    logic                        w_cv, w_cr;
    arc_pkg::t_cmd               w_cmd;
    arc_pkg::t_res               w_res;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 5'd16;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    arc_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tdata[2:0]), .i_addr(s_axis_tdata[66:3]),
        .i_range_end(s_axis_tdata[130:67]), .i_offset_in_file(s_axis_tdata[194:131]),
        .i_access_flags(s_axis_tdata[226:195]), .i_map_id(s_axis_tdata[242:227]),
        .i_has_mapping(s_axis_tdata[243]),
        .o_cmd_valid(w_cv), .i_cmd_ready(w_cr), .o_cmd(w_cmd)
    );

    arc_back #(.SLOTS(SLOTS)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_cv), .o_cmd_ready(w_cr), .i_cmd(w_cmd),
        .i_limit(r_limit),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {5'd0, w_res.evicted, w_res.translated, w_res.hit_flags,
                           w_res.hit_offset, w_res.hit_end, w_res.hit_start, w_res.status};

endmodule
